### hdl/lisp_token_scanner_macros.svh
// Assertion macros used by the scanner back end, lts_back.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef LISP_TOKEN_SCANNER_MACROS_SVH
`define LISP_TOKEN_SCANNER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define LTS_ASSERT_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/lts_pkg.sv
package lts_pkg;

   localparam int LTS_LINE_BYTES = 256;
   // Both queue depths are powers of two so that the pointers wrap by themselves.
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;
   localparam int KW_COUNT = 7;

   typedef enum logic [3:0] {
      KIND_LPAREN = 4'd0,
      KIND_RPAREN = 4'd1,
      KIND_OPER   = 4'd2,
      KIND_INT    = 4'd3,
      KIND_DEC    = 4'd4,
      KIND_QUOTE  = 4'd5,
      KIND_STRING = 4'd6,
      KIND_SYMBOL = 4'd7,
      KIND_DEFUN  = 4'd8,
      KIND_BOOL   = 4'd9,
      KIND_IF     = 4'd10,
      KIND_SETQ   = 4'd11,
      KIND_END    = 4'd12
   } kind_type;

   typedef enum logic [3:0] {
      CLS_BLANK,
      CLS_LPAREN,
      CLS_RPAREN,
      CLS_ANGLE,
      CLS_OPER,
      CLS_EQUAL,
      CLS_MINUS,
      CLS_QUOTE,
      CLS_DQUOTE,
      CLS_SEMI,
      CLS_DIGIT,
      CLS_DOT,
      CLS_ALPHA,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_end;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] token_start;
      logic [7:0] token_length;
      logic       last_of_run;
   } rsp_type;

   // A classified item as it waits between the front and the back.
   typedef struct packed {
      logic [7:0] text_byte;
      cls_type    cls;
      logic       line_end;
      logic       end_of_input;
      logic [7:0] start_pos;
      logic [7:0] next_pos;
   } mid_type;

   // Keyword text, first character in the low byte, unused bytes zero.
   localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
      40'h6E75666564,   // defun
      40'h0000000054,   // T
      40'h00004C494E,   // NIL
      40'h0000006669,   // if
      40'h0071746573,   // setq
      40'h0000646F6D,   // mod
      40'h0000007165    // eq
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{
      8'd5, 8'd1, 8'd3, 8'd2, 8'd4, 8'd3, 8'd2
   };
   localparam kind_type KW_KIND [KW_COUNT] = '{
      KIND_DEFUN, KIND_BOOL, KIND_BOOL, KIND_IF, KIND_SETQ, KIND_OPER, KIND_OPER
   };

endpackage

### hdl/lisp_token_scanner.sv
// Streaming Lisp token scanner.
// Input channel: one source byte per item on req_data (text_byte, line_end,
// end_of_input), taken at a clock edge with push high and full low.
// Result channel: typed tokens on rsp_data (token_kind, token_start,
// token_length, last_of_run); the oldest token is shown while empty is low and
// is taken at a clock edge with pop high. One item causes zero, one or two
// tokens, and last_of_run marks the final token of an item.
// A byte passes the front into the mid queue; the scanner step in the back end
// then writes the token that it completes into the result queue, from which it
// can be popped. The back takes one item per cycle while the result queue has
// room for two tokens; the result side moves one token per cycle, so a byte
// that closes two tokens adds two entries to the result queue.
// A four-entry queue parts the classifying front from the scanner, and the
// scanner takes an item only while its four-entry result queue has room for
// two tokens. When the receiver stalls, both queues fill and full rises.
// Reset empties both queues, leaves the scanner idle between tokens and sets
// the line offset to zero. No clearing pass is needed after reset.
module lisp_token_scanner import lts_pkg::*; #(
   parameter int LINE_BYTES = LTS_LINE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   // Front to queue: classified items with their line offsets.
   logic    mid_push;
   logic    mid_full;
   mid_type mid_in;

   // Queue to back.
   logic    mid_pop;
   logic    mid_empty;
   mid_type mid_out;

   // The front classifies each byte and keeps the line offset, which depends
   // only on the sequence of line and input ends and so runs ahead of the scanner.
   lts_front #(
      .LINE_BYTES(LINE_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .mid_push (mid_push),
      .mid_item (mid_in),
      .mid_full (mid_full)
   );

   lts_mid_queue u_mid_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (mid_push),
      .item_in  (mid_in),
      .full     (mid_full),
      .pop      (mid_pop),
      .empty    (mid_empty),
      .item_out (mid_out)
   );

   // The back runs the token state machine and holds the result queue.
   lts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_item  (mid_out),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/lts_front.sv
module lts_front import lts_pkg::*; #(
   parameter int LINE_BYTES = LTS_LINE_BYTES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   output logic    mid_push,
   output mid_type mid_item,
   input  logic    mid_full
);

   localparam int PW = $clog2(LINE_BYTES);
   localparam logic [PW-1:0] POS_LAST = PW'(LINE_BYTES - 1);

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_MORE   = 8'h3E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_TICK   = 8'h27;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DOT    = 8'h2E;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      case (b) inside
         CH_SPACE, CH_TAB, CH_CR, CH_LF: c = CLS_BLANK;
         CH_LPAREN:                      c = CLS_LPAREN;
         CH_RPAREN:                      c = CLS_RPAREN;
         CH_LESS, CH_MORE:               c = CLS_ANGLE;
         CH_SLASH, CH_PLUS, CH_STAR:     c = CLS_OPER;
         CH_EQUAL:                       c = CLS_EQUAL;
         CH_MINUS:                       c = CLS_MINUS;
         CH_TICK, CH_BTICK:              c = CLS_QUOTE;
         CH_DQUOTE:                      c = CLS_DQUOTE;
         CH_SEMI:                        c = CLS_SEMI;
         CH_DOT:                         c = CLS_DOT;
         [8'h30:8'h39]:                  c = CLS_DIGIT;
         [8'h41:8'h5A], [8'h61:8'h7A]:   c = CLS_ALPHA;
         default:                        c = CLS_OTHER;
      endcase
      return c;
   endfunction

   logic [PW-1:0] pos_ff, pos_in;
   logic [31:0]   pos_wide;
   logic          accept;

   assign full     = mid_full;
   assign accept   = push && !mid_full;
   assign mid_push = accept;
   assign pos_wide = 32'(pos_ff);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_data.end_of_input || req_data.line_end) begin
            pos_in = '0;
         end else if (pos_ff != POS_LAST) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      mid_item.text_byte    = req_data.text_byte;
      mid_item.cls          = classify(req_data.text_byte);
      mid_item.line_end     = req_data.line_end;
      mid_item.end_of_input = req_data.end_of_input;
      mid_item.start_pos    = (pos_wide > 32'd255) ? 8'hFF : pos_wide[7:0];
      mid_item.next_pos     = (pos_wide >= 32'd255) ? 8'hFF : 8'(pos_wide + 32'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### hdl/lts_mid_queue.sv
module lts_mid_queue import lts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  mid_type item_in,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output mid_type item_out
);

   localparam int AW = $clog2(MID_DEPTH);

   mid_type       slot_ff [MID_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == (AW + 1)'(MID_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign item_out = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + (AW + 1)'(do_push) - (AW + 1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

### hdl/lts_back.sv
`include "lisp_token_scanner_macros.svh"

module lts_back import lts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  mid_type mid_item,
   input  logic    mid_empty,
   output logic    mid_pop,
   input  logic    rsp_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data
);

   localparam int QW = $clog2(OUT_DEPTH);
   localparam int CW = QW + 1;

   typedef enum logic [8:0] {
      MODE_IDLE    = 9'b000000001,
      MODE_LPAREN  = 9'b000000010,
      MODE_ANGLE   = 9'b000000100,
      MODE_MINUS   = 9'b000001000,
      MODE_INT     = 9'b000010000,
      MODE_DEC     = 9'b000100000,
      MODE_SYM     = 9'b001000000,
      MODE_STR     = 9'b010000000,
      MODE_COMMENT = 9'b100000000
   } mode_type;

   typedef struct packed {
      logic       v;
      logic [3:0] kind;
      logic [7:0] start;
      logic [7:0] len;
   } tok_type;

   function automatic tok_type mk_tok(input kind_type k, input logic [7:0] s,
                                      input logic [7:0] n);
      tok_type t;
      t.v     = 1'b1;
      t.kind  = k;
      t.start = s;
      t.len   = n;
      return t;
   endfunction

   function automatic logic [7:0] grow8(input logic [7:0] n);
      return (n == 8'hFF) ? n : n + 8'd1;
   endfunction

   function automatic kind_type sym_kind(input logic [39:0] ch, input logic [7:0] n,
                                         input logic lg);
      kind_type k;
      k = KIND_SYMBOL;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (!lg && KW_LEN[i] == n && KW_TEXT[i] == ch) begin
            k = KW_KIND[i];
         end
      end
      return k;
   endfunction

   function automatic tok_type flush_tok(input mode_type m, input logic [7:0] s,
                                         input logic [7:0] n, input logic [39:0] ch,
                                         input logic lg);
      tok_type t;
      case (m)
         MODE_LPAREN:            t = mk_tok(KIND_LPAREN, s, 8'd1);
         MODE_ANGLE, MODE_MINUS: t = mk_tok(KIND_OPER, s, 8'd1);
         MODE_INT:               t = mk_tok(KIND_INT, s, n);
         MODE_DEC:               t = mk_tok(KIND_DEC, s, n);
         MODE_SYM:               t = mk_tok(sym_kind(ch, n, lg), s, n);
         MODE_STR:               t = mk_tok(KIND_STRING, s, n);
         default:                t = '0;
      endcase
      return t;
   endfunction

   // Scanner state.
   mode_type    mode_ff, mode_in, mode_m;
   logic [7:0]  start_ff, start_in, start_m;
   logic [7:0]  len_ff, len_in, len_m;
   logic [39:0] chars_ff, chars_in, chars_m;
   logic        long_ff, long_in, long_m;

   // Result queue.
   rsp_type     q_ff [OUT_DEPTH];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   tok_type     tok_a, tok_b, tok_c, slot0, slot1;
   logic        do_start, take, rd;
   logic [1:0]  wr_n;
   rsp_type     res0, res1;
   logic [7:0]  c;
   logic        line_done, end_last;

   assign c         = mid_item.text_byte;
   // Take an item only when the result queue can hold both tokens it may cause.
   assign take      = !mid_empty && (count_ff <= CW'(OUT_DEPTH - 2));
   assign mid_pop   = take;
   assign rsp_empty = (count_ff == '0);
   assign rd        = rsp_pop && !rsp_empty;
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_comb begin
      tok_a    = '0;
      tok_b    = '0;
      tok_c    = '0;
      mode_m   = mode_ff;
      start_m  = start_ff;
      len_m    = len_ff;
      chars_m  = chars_ff;
      long_m   = long_ff;
      do_start = 1'b0;
      if (mid_item.end_of_input) begin
         tok_a  = flush_tok(mode_ff, start_ff, len_ff, chars_ff, long_ff);
         tok_c  = mk_tok(KIND_END, 8'd0, 8'd0);
         mode_m = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_IDLE: begin
               do_start = 1'b1;
            end
            MODE_LPAREN: begin
               if (mid_item.cls == CLS_RPAREN) begin
                  tok_a  = mk_tok(KIND_BOOL, start_ff, 8'd2);
                  mode_m = MODE_IDLE;
               end else begin
                  tok_a    = mk_tok(KIND_LPAREN, start_ff, 8'd1);
                  do_start = 1'b1;
               end
            end
            MODE_ANGLE: begin
               if (mid_item.cls == CLS_EQUAL) begin
                  tok_a  = mk_tok(KIND_OPER, start_ff, 8'd2);
                  mode_m = MODE_IDLE;
               end else begin
                  tok_a    = mk_tok(KIND_OPER, start_ff, 8'd1);
                  do_start = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (mid_item.cls == CLS_DIGIT) begin
                  len_m  = grow8(len_ff);
                  mode_m = MODE_INT;
               end else begin
                  tok_a    = mk_tok(KIND_OPER, start_ff, 8'd1);
                  do_start = 1'b1;
               end
            end
            MODE_INT: begin
               if (mid_item.cls == CLS_DIGIT) begin
                  len_m = grow8(len_ff);
               end else if (mid_item.cls == CLS_DOT) begin
                  len_m  = grow8(len_ff);
                  mode_m = MODE_DEC;
               end else begin
                  tok_a    = mk_tok(KIND_INT, start_ff, len_ff);
                  do_start = 1'b1;
               end
            end
            MODE_DEC: begin
               if (mid_item.cls == CLS_DIGIT) begin
                  len_m = grow8(len_ff);
               end else begin
                  tok_a    = mk_tok(KIND_DEC, start_ff, len_ff);
                  do_start = 1'b1;
               end
            end
            MODE_SYM: begin
               if (mid_item.cls == CLS_DIGIT || mid_item.cls == CLS_ALPHA) begin
                  // Only the first five characters are kept for keyword matching.
                  for (int i = 0; i < 5; i++) begin
                     if (len_ff == 8'(i)) begin
                        chars_m[8*i +: 8] = c;
                     end
                  end
                  if (len_ff >= 8'd5) begin
                     long_m = 1'b1;
                  end
                  len_m = grow8(len_ff);
               end else begin
                  tok_a    = mk_tok(sym_kind(chars_ff, len_ff, long_ff), start_ff, len_ff);
                  do_start = 1'b1;
               end
            end
            MODE_STR: begin
               if (mid_item.cls == CLS_DQUOTE) begin
                  tok_a  = mk_tok(KIND_STRING, start_ff, len_ff);
                  mode_m = MODE_IDLE;
               end else begin
                  len_m = grow8(len_ff);
               end
            end
            MODE_COMMENT: begin
               mode_m = MODE_COMMENT;
            end
            default: begin
               mode_m = MODE_IDLE;
            end
         endcase

         if (do_start) begin
            mode_m  = MODE_IDLE;
            start_m = mid_item.start_pos;
            len_m   = 8'd1;
            chars_m = '0;
            long_m  = 1'b0;
            case (mid_item.cls)
               CLS_BLANK:           mode_m = MODE_IDLE;
               CLS_LPAREN:          mode_m = MODE_LPAREN;
               CLS_RPAREN:          tok_b  = mk_tok(KIND_RPAREN, mid_item.start_pos, 8'd1);
               CLS_ANGLE:           mode_m = MODE_ANGLE;
               CLS_OPER, CLS_EQUAL: tok_b  = mk_tok(KIND_OPER, mid_item.start_pos, 8'd1);
               CLS_MINUS:           mode_m = MODE_MINUS;
               CLS_QUOTE:           tok_b  = mk_tok(KIND_QUOTE, mid_item.start_pos, 8'd1);
               CLS_DQUOTE: begin
                  mode_m  = MODE_STR;
                  start_m = mid_item.next_pos;
                  len_m   = 8'd0;
               end
               CLS_SEMI:            mode_m = MODE_COMMENT;
               CLS_DIGIT:           mode_m = MODE_INT;
               default: begin
                  mode_m  = MODE_SYM;
                  chars_m = {32'd0, c};
               end
            endcase
         end

         if (mid_item.line_end) begin
            tok_c  = flush_tok(mode_m, start_m, len_m, chars_m, long_m);
            mode_m = MODE_IDLE;
         end
      end
   end

   // At most two of the three candidate tokens are ever valid together.
   always_comb begin
      slot0 = tok_a.v ? tok_a : (tok_b.v ? tok_b : tok_c);
      if (tok_a.v) begin
         slot1 = tok_b.v ? tok_b : tok_c;
      end else begin
         slot1 = tok_b.v ? tok_c : '0;
      end
      wr_n = take ? (2'(slot0.v) + 2'(slot1.v)) : 2'd0;

      res0.token_kind   = slot0.kind;
      res0.token_start  = slot0.start;
      res0.token_length = slot0.len;
      res0.last_of_run  = !slot1.v;
      res1.token_kind   = slot1.kind;
      res1.token_start  = slot1.start;
      res1.token_length = slot1.len;
      res1.last_of_run  = 1'b1;
   end

   always_comb begin
      mode_in   = take ? mode_m : mode_ff;
      start_in  = take ? start_m : start_ff;
      len_in    = take ? len_m : len_ff;
      chars_in  = take ? chars_m : chars_ff;
      long_in   = take ? long_m : long_ff;
      wr_ptr_in = wr_ptr_ff + QW'(wr_n);
      rd_ptr_in = rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(wr_n) - CW'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
      chars_ff <= chars_in;
      long_ff  <= long_in;
      if (wr_n != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (wr_n == 2'd2) begin
         q_ff[wr_ptr_ff + 1'b1] <= res1;
      end
   end

   // The end token, when present, is the final token written for its item.
   assign line_done = take && (mid_item.line_end || mid_item.end_of_input);
   assign end_last  = slot1.v ? (slot1.kind == KIND_END) : (slot0.v && slot0.kind == KIND_END);

   `LTS_ASSERT_NOW(a_count_bound, count_ff <= CW'(OUT_DEPTH), "result queue overflow")
   `LTS_ASSERT_NEXT(a_idle_after_line, line_done, mode_ff == MODE_IDLE, "scanner not idle")
   `LTS_ASSERT_NOW(a_end_last, (take && mid_item.end_of_input) |-> end_last, "end not last")
   `LTS_ASSERT_NEXT(a_result_visible, wr_n != 2'd0, !rsp_empty, "written token not visible")

endmodule

### sim/token_stream_check.sv
`timescale 1ns / 100ps

// Watches both channels of the scanner, works out the tokens that each
// accepted byte should produce and compares every popped token against the
// oldest one still outstanding.
module token_stream_check import lts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      tokens_due
);

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_LPAREN,
      SCAN_ANGLE,
      SCAN_MINUS,
      SCAN_INT,
      SCAN_DEC,
      SCAN_SYM,
      SCAN_STR,
      SCAN_COMMENT
   } scan_state_type;

   localparam int LAST_POS    = LTS_LINE_BYTES - 1;
   localparam int MAX_REPORTS = 10;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKQUOTE = 8'h60;

   // Keywords are written last character first, so that the first character
   // lands in the low byte, the order in which symbol characters are collected.
   localparam logic [39:0] WORD_DEFUN = "nufed";
   localparam logic [39:0] WORD_T     = "T";
   localparam logic [39:0] WORD_NIL   = "LIN";
   localparam logic [39:0] WORD_IF    = "fi";
   localparam logic [39:0] WORD_SETQ  = "qtes";
   localparam logic [39:0] WORD_MOD   = "dom";
   localparam logic [39:0] WORD_EQ    = "qe";

   scan_state_type scan_state;
   int             line_pos;
   int             tok_start;
   int             tok_len;
   logic [39:0]    word_chars;
   logic           word_long;

   rsp_type        step_tokens [2];
   int             step_count;
   rsp_type        predicted_tokens [$];
   int             misses;

   function automatic logic [7:0] clip8(input int v);
      return (v > 255) ? 8'hFF : v[7:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic logic is_alnum(input logic [7:0] ch);
      return is_digit(ch) || (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
   endfunction

   task automatic clear_state();
      scan_state = SCAN_IDLE;
      line_pos   = 0;
      tok_start  = 0;
      tok_len    = 0;
      word_chars = '0;
      word_long  = 1'b0;
   endtask

   // At most two tokens come out of one byte; anything beyond is dropped.
   task automatic add_token(input kind_type kind, input int start, input int len);
      if (step_count < 2) begin
         step_tokens[step_count].token_kind   = kind;
         step_tokens[step_count].token_start  = clip8(start);
         step_tokens[step_count].token_length = clip8(len);
         step_tokens[step_count].last_of_run  = 1'b0;
         step_count++;
      end
   endtask

   task automatic extend();
      if (tok_len < 255) tok_len++;
   endtask

   // Only the first five characters are kept; longer symbols are never keywords.
   task automatic word_add(input logic [7:0] ch);
      if (tok_len < 5) word_chars[8 * tok_len +: 8] = ch;
      else word_long = 1'b1;
      extend();
   endtask

   function automatic kind_type word_kind();
      logic [7:0] len8;
      len8 = 8'(tok_len);
      if (word_long) return KIND_SYMBOL;
      case ({len8, word_chars})
         {8'd5, WORD_DEFUN}: return KIND_DEFUN;
         {8'd1, WORD_T}:     return KIND_BOOL;
         {8'd3, WORD_NIL}:   return KIND_BOOL;
         {8'd2, WORD_IF}:    return KIND_IF;
         {8'd4, WORD_SETQ}:  return KIND_SETQ;
         {8'd3, WORD_MOD}:   return KIND_OPER;
         {8'd2, WORD_EQ}:    return KIND_OPER;
         default:            return KIND_SYMBOL;
      endcase
   endfunction

   task automatic begin_token(input scan_state_type next_state, input int start);
      scan_state = next_state;
      tok_start  = start;
      tok_len    = 1;
      word_chars = '0;
      word_long  = 1'b0;
   endtask

   task automatic open_token(input logic [7:0] ch, input int pos);
      scan_state = SCAN_IDLE;
      case (ch)
         " ", CH_TAB, CH_CR, CH_LF: ;
         "(":                 begin_token(SCAN_LPAREN, pos);
         ")":                 add_token(KIND_RPAREN, pos, 1);
         "<", ">":            begin_token(SCAN_ANGLE, pos);
         "/", "+", "*", "=":  add_token(KIND_OPER, pos, 1);
         "-":                 begin_token(SCAN_MINUS, pos);
         "'", CH_BACKQUOTE:   add_token(KIND_QUOTE, pos, 1);
         CH_DQUOTE: begin
            begin_token(SCAN_STR, pos + 1);
            tok_len = 0;
         end
         ";":                 scan_state = SCAN_COMMENT;
         default: begin
            if (is_digit(ch)) begin
               begin_token(SCAN_INT, pos);
            end else begin
               begin_token(SCAN_SYM, pos);
               tok_len = 0;
               word_add(ch);
            end
         end
      endcase
   endtask

   task automatic close_pending();
      case (scan_state)
         SCAN_LPAREN:            add_token(KIND_LPAREN, tok_start, 1);
         SCAN_ANGLE, SCAN_MINUS: add_token(KIND_OPER, tok_start, 1);
         SCAN_INT:               add_token(KIND_INT, tok_start, tok_len);
         SCAN_DEC:               add_token(KIND_DEC, tok_start, tok_len);
         SCAN_SYM:               add_token(word_kind(), tok_start, tok_len);
         SCAN_STR:               add_token(KIND_STRING, tok_start, tok_len);
         default: ;
      endcase
      scan_state = SCAN_IDLE;
   endtask

   task automatic scan_byte(input req_type item);
      logic [7:0] ch;
      int         pos;
      ch = item.text_byte;
      pos = line_pos;
      step_count = 0;
      if (item.end_of_input) begin
         close_pending();
         add_token(KIND_END, 0, 0);
         clear_state();
      end else begin
         case (scan_state)
            SCAN_IDLE: open_token(ch, pos);
            SCAN_LPAREN: begin
               if (ch == ")") begin
                  add_token(KIND_BOOL, tok_start, 2);
                  scan_state = SCAN_IDLE;
               end else begin
                  add_token(KIND_LPAREN, tok_start, 1);
                  open_token(ch, pos);
               end
            end
            SCAN_ANGLE: begin
               if (ch == "=") begin
                  add_token(KIND_OPER, tok_start, 2);
                  scan_state = SCAN_IDLE;
               end else begin
                  add_token(KIND_OPER, tok_start, 1);
                  open_token(ch, pos);
               end
            end
            SCAN_MINUS: begin
               if (is_digit(ch)) begin
                  extend();
                  scan_state = SCAN_INT;
               end else begin
                  add_token(KIND_OPER, tok_start, 1);
                  open_token(ch, pos);
               end
            end
            SCAN_INT: begin
               if (is_digit(ch)) begin
                  extend();
               end else if (ch == ".") begin
                  extend();
                  scan_state = SCAN_DEC;
               end else begin
                  add_token(KIND_INT, tok_start, tok_len);
                  open_token(ch, pos);
               end
            end
            SCAN_DEC: begin
               if (is_digit(ch)) begin
                  extend();
               end else begin
                  add_token(KIND_DEC, tok_start, tok_len);
                  open_token(ch, pos);
               end
            end
            SCAN_SYM: begin
               if (is_alnum(ch)) begin
                  word_add(ch);
               end else begin
                  add_token(word_kind(), tok_start, tok_len);
                  open_token(ch, pos);
               end
            end
            SCAN_STR: begin
               if (ch == CH_DQUOTE) begin
                  add_token(KIND_STRING, tok_start, tok_len);
                  scan_state = SCAN_IDLE;
               end else begin
                  extend();
               end
            end
            default: ;
         endcase
         if (item.line_end) begin
            close_pending();
            line_pos = 0;
         end else if (line_pos < LAST_POS) begin
            line_pos++;
         end
      end
      if (step_count > 0) step_tokens[step_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < step_count; i++) predicted_tokens.push_back(step_tokens[i]);
   endtask

   task automatic check_token(input rsp_type got);
      rsp_type want;
      if (predicted_tokens.size() == 0) begin
         misses++;
         if (misses <= MAX_REPORTS)
            $display("%0t: unexpected token kind %0d start %0d length %0d last %0b",
                     $realtime, got.token_kind, got.token_start, got.token_length,
                     got.last_of_run);
      end else begin
         want = predicted_tokens.pop_front();
         if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
             got.token_length !== want.token_length ||
             got.last_of_run !== want.last_of_run) begin
            misses++;
            if (misses <= MAX_REPORTS) begin
               $write("%0t: token mismatch, expected kind %0d start %0d length %0d last %0b,",
                      $realtime, want.token_kind, want.token_start, want.token_length,
                      want.last_of_run);
               $display(" got kind %0d start %0d length %0d last %0b",
                        got.token_kind, got.token_start, got.token_length,
                        got.last_of_run);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         predicted_tokens.delete();
      end else begin
         if (pop && !empty) check_token(rsp_data);
         if (push && !full) scan_byte(req_data);
      end
      fail_count <= misses;
      tokens_due <= predicted_tokens.size();
   end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

// Top of the scanner test. It builds lines of Lisp-like source text, feeds
// them byte by byte through the input queue and pops tokens at random. The
// prediction and comparison live in token_stream_check; this module only
// makes stimulus and reports the verdict.
module tb_top import lts_pkg::*; ();

   // The limit leaves a wide margin over the slowest legal run, even with
   // both sides idling most of the time.
   localparam int CYCLE_LIMIT = 400000;
   // Least number of queued items per phase; the long line counts toward it.
   localparam int PHASE_ITEMS = 200;

   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_BACKQUOTE = 8'h60;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   logic    empty;
   logic    pop;
   req_type req_data;
   rsp_type rsp_data;

   int fail_count;
   int tokens_due;
   int stall_pct;
   int cycle_count;

   // Bytes of the line under construction, and items ready to be sent.
   logic [7:0] line_text [$];
   req_type    text_items [$];

   lisp_token_scanner DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   token_stream_check tokens_check (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .tokens_due (tokens_due)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The receiver decides at every falling edge whether it takes a token at
   // the next rising edge. stall_pct is changed by the phases below.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung block or a lost token ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] pick_alnum(input int lo);
      int r;
      r = $urandom_range(61, lo);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("a" + r - 10);
      return 8'("A" + r - 36);
   endfunction

   // Any byte but the closing double quote can sit inside a string.
   function automatic logic [7:0] string_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == CH_DQUOTE);
      return b;
   endfunction

   function automatic string keyword(input int k);
      case (k)
         0:       return "defun";
         1:       return "T";
         2:       return "NIL";
         3:       return "if";
         4:       return "setq";
         5:       return "mod";
         default: return "eq";
      endcase
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) line_text.push_back(s[i]);
   endtask

   task automatic put_blank();
      case ($urandom_range(3))
         0:       line_text.push_back(" ");
         1:       line_text.push_back(CH_TAB);
         2:       line_text.push_back(CH_CR);
         default: line_text.push_back(CH_LF);
      endcase
   endtask

   // Moves the pending line bytes into the send queue. With mark_last the
   // final byte carries line_end; an empty line then becomes a single blank.
   task automatic move_text(input logic mark_last);
      req_type item;
      if (mark_last && line_text.size() == 0) line_text.push_back(" ");
      while (line_text.size() > 0) begin
         item.text_byte    = line_text.pop_front();
         item.line_end     = mark_last && (line_text.size() == 0);
         item.end_of_input = 1'b0;
         text_items.push_back(item);
      end
   endtask

   // Ends the input, possibly in the middle of a line. The text byte and the
   // line_end flag of the end item are meant to be ignored by the block.
   task automatic put_finish(input logic [7:0] junk, input logic junk_end);
      req_type item;
      move_text(1'b0);
      item.text_byte    = junk;
      item.line_end     = junk_end;
      item.end_of_input = 1'b1;
      text_items.push_back(item);
   endtask

   // One lexical piece. Most pieces are well formed tokens with random
   // content; a few are raw noise bytes that may open anything.
   task automatic put_piece();
      string ops;
      ops = "/+*=";
      case ($urandom_range(14))
         0: put_text("(");
         1: put_text(")");
         2: put_text("()");
         3: begin
            put_text($urandom_range(1) ? "<" : ">");
            if ($urandom_range(1)) put_text("=");
         end
         4: line_text.push_back(ops[$urandom_range(3)]);
         5: put_text("-");
         6: begin
            if ($urandom_range(2) == 0) put_text("-");
            repeat ($urandom_range(4, 1)) line_text.push_back(pick_alnum(0) % 8'd10 + "0");
         end
         7: begin
            repeat ($urandom_range(3, 1)) line_text.push_back(8'("0" + $urandom_range(9)));
            put_text(".");
            repeat ($urandom_range(3, 0)) line_text.push_back(8'("0" + $urandom_range(9)));
         end
         8: line_text.push_back($urandom_range(1) ? 8'("'") : CH_BACKQUOTE);
         9: begin
            line_text.push_back(CH_DQUOTE);
            repeat ($urandom_range(5, 0)) line_text.push_back(string_byte());
            line_text.push_back(CH_DQUOTE);
         end
         10: put_text(keyword($urandom_range(6)));
         11: begin
            // Keyword look-alikes: one more character, so no keyword match.
            put_text(keyword($urandom_range(6)));
            line_text.push_back(pick_alnum(0));
         end
         12: begin
            line_text.push_back(pick_alnum(10));
            repeat ($urandom_range(6, 0)) line_text.push_back(pick_alnum(0));
         end
         13: line_text.push_back(8'($urandom_range(255)));
         default: put_blank();
      endcase
   endtask

   // A random line of pieces, sometimes ending in a comment or in a string
   // that the line end has to close. Now and then the input ends, either
   // after the line or in the middle of it.
   task automatic make_line();
      int pieces;
      pieces = $urandom_range(10, 1);
      repeat (pieces) begin
         put_piece();
         if ($urandom_range(99) < 55) put_blank();
         if ($urandom_range(99) < 2) begin
            put_finish(8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
      case ($urandom_range(9))
         0: begin
            put_text(";");
            repeat ($urandom_range(5, 0)) line_text.push_back(8'($urandom_range(255)));
         end
         1: begin
            line_text.push_back(CH_DQUOTE);
            repeat ($urandom_range(4, 0)) line_text.push_back(string_byte());
         end
         default: ;
      endcase
      move_text(1'b1);
      if ($urandom_range(99) < 6) put_finish(8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // A line longer than the line buffer. Its first token outgrows the length
   // field, and the tokens after it sit at the saturated line offset; the
   // string that follows would start one past the last offset.
   task automatic make_long_line();
      int body;
      body = $urandom_range(275, 256);
      case ($urandom_range(2))
         0: begin
            put_text("s");
            repeat (body) line_text.push_back(pick_alnum(0));
         end
         1: repeat (body) line_text.push_back(8'("0" + $urandom_range(9)));
         default: begin
            line_text.push_back(CH_DQUOTE);
            repeat (body) line_text.push_back(string_byte());
            line_text.push_back(CH_DQUOTE);
         end
      endcase
      line_text.push_back(CH_DQUOTE);
      put_text("ab");
      line_text.push_back(CH_DQUOTE);
      put_text(" (x 12) ");
      move_text(1'b1);
   endtask

   // Sends every queued item. Inputs change only at falling edges, and an
   // item counts as taken at the rising edge where full is low. Each falling
   // edge sees exactly one assignment to push.
   task automatic send_all(input int idle_pct);
      req_type item;
      while (text_items.size() > 0) begin
         item = text_items.pop_front();
         while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge clock);
         end
         push     <= 1'b1;
         req_data <= item;
         do @(posedge clock); while (full);
         @(negedge clock);
      end
      push <= 1'b0;
   endtask

   // Holds the sender back until every predicted token has been popped, and
   // then still waits in case a byte left the block busy.
   task automatic wait_drained();
      while (tokens_due != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input logic long_line);
      stall_pct = stall;
      if (long_line) make_long_line();
      while (text_items.size() < PHASE_ITEMS) make_line();
      send_all(idle_pct);
      wait_drained();
   endtask

   initial begin
      reset    = 1'b1;
      push     = 1'b0;
      req_data = '0;
      stall_pct = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines. The first has an empty list, a compare operator with
      // its equal sign, a minus before a blank, a decimal, a quote and a
      // string left open at line end. The second has the boolean T, an angle
      // without equal sign and a minus that ends the line. Then the input
      // ends with an all-ones byte, a line with eq and a comment follows, and
      // the last line holds the all-zero and the all-ones byte as symbols.
      put_text("()<=- 12.5'");
      line_text.push_back(CH_DQUOTE);
      put_text("s");
      move_text(1'b1);
      put_text("(T>a-");
      move_text(1'b1);
      put_finish(8'hFF, 1'b1);
      put_text("eq;c");
      move_text(1'b1);
      line_text.push_back(8'h00);
      line_text.push_back(8'hFF);
      move_text(1'b1);
      send_all(0);
      wait_drained();

      // Random phases. Every phase ends with the sender paused until all
      // tokens are out, so the queues run both full and dry.
      run_phase(0, 0, 1'b1);
      run_phase(87, 0, 1'b0);
      run_phase(0, 87, 1'b0);
      run_phase(31, 31, 1'b0);
      run_phase(0, 0, 1'b1);

      if (fail_count == 0 && tokens_due == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/lts_pkg.sv
hdl/lts_front.sv
hdl/lts_mid_queue.sv
hdl/lts_back.sv
hdl/lisp_token_scanner.sv
sim/token_stream_check.sv
sim/tb_top.sv
